// ===== rtl/core/tmhq_pkg.sv =====
package tmhq_pkg;

    localparam int CAPACITY  = 64;
    localparam int ARITY     = 3;
    localparam int KEY_WIDTH = 32;

    // fixed field widths of the streams
    localparam int CMD_W   = 2;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int CNTF_W  = 7;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ALOG_W  = $clog2(ARITY);
    localparam int CHILD_W = ADDR_W + ALOG_W + 1;
    localparam int CMP_W   = CNT_W + POS_W;

    // parent = (slot - 1) / ARITY through a reciprocal, exact for slot < 2**ADDR_W
    localparam int RECIP_S = ADDR_W + ALOG_W;
    localparam int RECIP_M = ((1 << RECIP_S) + ARITY - 1) / ARITY;
    localparam int PROD_W  = ADDR_W + RECIP_S + 1;

    localparam int S_TDATA_W = ((CMD_W + KEY_WIDTH + POS_W + 7) / 8) * 8;
    localparam int M_FIELD_W = KEY_WIDTH + STAT_W + CNTF_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECREASE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_REJECT = 2'd3;

    typedef logic signed [KEY_WIDTH-1:0] key_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EX_ROOT,
        S_EX_LAST,
        S_DEC_CMP,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_START,
        S_DN_SCAN,
        S_DN_DECIDE,
        S_FIN
    } state_t;

    typedef struct packed {
        key_t              result_key;
        logic [STAT_W-1:0] status;
        logic [CNTF_W-1:0] entry_count;
    } res_t;

    function automatic logic [ADDR_W-1:0] tmhq_parent(input logic [ADDR_W-1:0] slot);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(slot - ADDR_W'(1)) * PROD_W'(RECIP_M);
        return ADDR_W'(prod >> RECIP_S);
    endfunction

endpackage

// ===== rtl/core/tmhq_ram.sv =====
module tmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tmhq_ctrl.sv =====
module tmhq_ctrl
    import tmhq_pkg::*;
(
    input  logic              clk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  in_cmd,
    input  key_t              in_key,
    input  logic [POS_W-1:0]  in_pos,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res
);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    hole_reg, hole_next;
    key_t                 key_reg, key_next;
    key_t                 result_reg, result_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    key_t                 best_reg, best_next;
    logic [ADDR_W-1:0]    best_idx_reg, best_idx_next;
    logic [ADDR_W-1:0]    ci_reg, ci_next;
    logic [ADDR_W-1:0]    last_reg, last_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    key_t                 ram_wdata;
    logic [KEY_WIDTH-1:0] ram_rdata;
    key_t                 rd_key;

    logic [CHILD_W-1:0]   child_first, child_end, cnt_m1;
    logic [ADDR_W-1:0]    child_last;
    logic                 accept, is_full, is_empty, pos_bad, dec_bigger;
    logic                 up_root, up_move, dn_leaf, scan_take, scan_end, dn_stop;

    tmhq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key = key_t'(ram_rdata);

    assign child_first = CHILD_W'(hole_reg) * CHILD_W'(ARITY) + CHILD_W'(1);
    assign child_end   = child_first + CHILD_W'(ARITY - 1);
    assign cnt_m1      = CHILD_W'(count_reg) - CHILD_W'(1);
    assign child_last  = (child_end > cnt_m1) ? ADDR_W'(cnt_m1) : ADDR_W'(child_end);

    assign accept     = in_valid && in_ready;
    assign is_full    = count_reg >= CNT_W'(CAPACITY);
    assign is_empty   = count_reg == '0;
    assign pos_bad    = CMP_W'(in_pos) >= CMP_W'(count_reg);
    assign dec_bigger = key_reg > rd_key;
    assign up_root    = hole_reg == '0;
    assign up_move    = rd_key > key_reg;
    assign dn_leaf    = child_first >= CHILD_W'(count_reg);
    // first child always taken, later ones only when strictly smaller
    assign scan_take  = (ci_reg == ADDR_W'(child_first)) || (rd_key < best_reg);
    assign scan_end   = ci_reg == last_reg;
    assign dn_stop    = key_reg <= best_reg;

    assign in_ready  = state_reg == S_IDLE;
    assign res_valid = state_reg == S_FIN;
    assign res.result_key  = result_reg;
    assign res.status      = status_reg;
    assign res.entry_count = CNTF_W'(count_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        CMD_INSERT:   state_next = is_full ? S_FIN : S_UP_CHK;
                        CMD_EXTRACT:  state_next = is_empty ? S_FIN : S_EX_ROOT;
                        CMD_DECREASE: state_next = (is_empty || pos_bad) ? S_FIN : S_DEC_CMP;
                        default:      state_next = S_FIN;
                    endcase
                end
            end
            S_EX_ROOT:   state_next = S_EX_LAST;
            S_EX_LAST:   state_next = is_empty ? S_FIN : S_DN_START;
            S_DEC_CMP:   state_next = dec_bigger ? S_FIN : S_UP_CHK;
            S_UP_CHK:    state_next = up_root ? S_FIN : S_UP_CMP;
            S_UP_CMP:    state_next = up_move ? S_UP_CHK : S_FIN;
            S_DN_START:  state_next = dn_leaf ? S_FIN : S_DN_SCAN;
            S_DN_SCAN:   state_next = scan_end ? S_DN_DECIDE : S_DN_SCAN;
            S_DN_DECIDE: state_next = dn_stop ? S_FIN : S_DN_START;
            S_FIN:       state_next = res_ready ? S_IDLE : S_FIN;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and store accesses
    always_comb begin
        count_next    = count_reg;
        hole_next     = hole_reg;
        key_next      = key_reg;
        result_next   = result_reg;
        status_next   = status_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        ci_next       = ci_reg;
        last_next     = last_reg;
        ram_we        = 1'b0;
        ram_waddr     = hole_reg;
        ram_wdata     = key_reg;
        ram_raddr     = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    result_next = '0;
                    status_next = STAT_OK;
                    key_next    = in_key;
                    unique case (in_cmd)
                        CMD_INSERT: begin
                            if (is_full) begin
                                status_next = STAT_FULL;
                            end else begin
                                hole_next  = ADDR_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_EXTRACT: begin
                            if (is_empty) begin
                                status_next = STAT_EMPTY;
                            end
                        end
                        CMD_DECREASE: begin
                            if (is_empty) begin
                                status_next = STAT_EMPTY;
                            end else if (pos_bad) begin
                                status_next = STAT_REJECT;
                            end else begin
                                ram_raddr = ADDR_W'(in_pos);
                                hole_next = ADDR_W'(in_pos);
                            end
                        end
                        default: status_next = STAT_REJECT;
                    endcase
                end
            end
            S_EX_ROOT: begin
                result_next = rd_key;
                ram_raddr   = ADDR_W'(count_reg - CNT_W'(1));
                count_next  = count_reg - CNT_W'(1);
            end
            S_EX_LAST: begin
                key_next  = rd_key;
                hole_next = '0;
            end
            S_DEC_CMP: begin
                if (dec_bigger) begin
                    status_next = STAT_REJECT;
                end
            end
            S_UP_CHK: begin
                if (up_root) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr     = tmhq_parent(hole_reg);
                    best_idx_next = tmhq_parent(hole_reg);
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (up_move) begin
                    ram_wdata = rd_key;
                    hole_next = best_idx_reg;
                end
            end
            S_DN_START: begin
                if (dn_leaf) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = ADDR_W'(child_first);
                    ci_next   = ADDR_W'(child_first);
                    last_next = child_last;
                end
            end
            S_DN_SCAN: begin
                if (scan_take) begin
                    best_next     = rd_key;
                    best_idx_next = ci_reg;
                end
                if (!scan_end) begin
                    ram_raddr = ci_reg + ADDR_W'(1);
                    ci_next   = ci_reg + ADDR_W'(1);
                end
            end
            S_DN_DECIDE: begin
                ram_we = 1'b1;
                if (!dn_stop) begin
                    ram_wdata = best_reg;
                    hole_next = best_idx_reg;
                end
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        hole_reg     <= hole_next;
        key_reg      <= key_next;
        result_reg   <= result_next;
        status_reg   <= status_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        ci_reg       <= ci_next;
        last_reg     <= last_next;
    end

endmodule

// ===== rtl/core/tmhq_out.sv =====
module tmhq_out
    import tmhq_pkg::*;
(
    input  logic clk,
    input  logic aresetn,
    input  logic res_valid,
    output logic res_ready,
    input  res_t res,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic valid_reg, valid_next;
    res_t data_reg;

    assign res_ready  = !valid_reg || out_ready;
    assign valid_next = (res_valid && res_ready) || (valid_reg && !out_ready);

    always_ff @(posedge clk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (res_valid && res_ready) begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

// ===== rtl/core/ternary_min_heap_queue_core.sv =====
// Ternary min-heap priority queue of up to CAPACITY signed keys, held in one
// single-port-read key store. Each request is a command (insert, extract
// minimum, decrease key at a slot) and yields exactly one result carrying the
// removed key (extract only), a status and the entry count after the command.
// One command is in work at a time, from the request taken to its result. A
// failing command (full, empty, bad slot, unused code) goes straight to the
// result, and a decrease to a larger key is rejected after reading the old key.
// Insert writes the key at the root of an empty queue; otherwise it reads the
// parent and moves each larger parent down as it climbs; a decrease first reads
// the old key at its slot. Extract reads the root and then the last key and ends
// there when the queue becomes empty; otherwise it scans the children of each
// level (one store read per child, then a decision and write-back) and writes
// the key where it settles. The key store has one read port, so these reads
// follow one another. The result sits in an output register, so a new command
// is taken while the previous result waits.
module ternary_min_heap_queue_core
    import tmhq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command [1:0], key [33:2], position [39:34]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_key [31:0], status [33:32], entry_count [40:34], zero above
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic res_valid, res_ready;
    res_t res, out_res;

    tmhq_ctrl u_ctrl (
        .clk       (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[CMD_W-1:0]),
        .in_key    (key_t'(s_tdata[CMD_W+KEY_WIDTH-1:CMD_W])),
        .in_pos    (s_tdata[CMD_W+KEY_WIDTH+POS_W-1:CMD_W+KEY_WIDTH]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    tmhq_out u_out (
        .clk       (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = M_TDATA_W'({out_res.entry_count, out_res.status, out_res.result_key});

    // one command in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while a command is in work");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status == STAT_FULL) |-> (res.entry_count == CNTF_W'(CAPACITY)))
        else $error("full reported below capacity");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status == STAT_EMPTY) |-> (res.entry_count == '0))
        else $error("empty reported with keys held");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (res.entry_count <= CNTF_W'(CAPACITY)))
        else $error("entry count beyond capacity");

    a_fail_zero_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status != STAT_OK) |-> (res.result_key == '0))
        else $error("failed command returned a key");

endmodule
